// ===== design/swsm_pkg.sv =====
// Package for the sliding window similarity matcher.
// Holds configuration register indexes and fixed field widths.
// No dependencies.
package swsm_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PAT_0_7   = 3'd0,
        REG_PAT_8_15  = 3'd1,
        REG_PAT_16_23 = 3'd2,
        REG_PAT_24_31 = 3'd3,
        REG_LENGTH    = 3'd4,
        REG_PERCENT   = 3'd5
    } t_reg_idx;

    localparam int CHAR_W     = 8;
    localparam int SEQ_W      = 8;
    localparam int POS_W      = 32;
    localparam int CNT_OUT_W  = 6;
    localparam int LEN_REG_W  = 6;
    localparam int PCT_W      = 7;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int PAT_REGS   = 4;
    localparam int PAT_CHARS  = 32;

    // Similarity percentage scale
    localparam int PCT_SCALE  = 100;

    localparam logic [PCT_W-1:0]     PCT_RESET = PCT_W'(100);
    localparam logic [LEN_REG_W-1:0] LEN_RESET = LEN_REG_W'(1);

endpackage

// ===== design/swsm_score.sv =====
// Match counter for the similarity matcher: compares each window slot with
// its aligned pattern character and counts the equal, enabled positions.
// Depends on swsm_pkg.
module swsm_score #(
    parameter int PATTERN_MAX = 32
) (
    input  logic [PATTERN_MAX-1:0][swsm_pkg::CHAR_W-1:0] i_window,
    input  logic [PATTERN_MAX-1:0][swsm_pkg::CHAR_W-1:0] i_pattern,
    input  logic [PATTERN_MAX-1:0]                       i_mask,
    output logic [$clog2(PATTERN_MAX+1)-1:0]             o_count
);
    import swsm_pkg::*;

    localparam int CW = $clog2(PATTERN_MAX + 1);

    logic [PATTERN_MAX-1:0] eq;

    // Per-slot compare
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            eq[j] = i_mask[j] && (i_window[j] == i_pattern[j]);
        end
    end

    // Population count of the equal slots
    always_comb begin
        o_count = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            o_count = o_count + CW'(eq[j]);
        end
    end

endmodule

// ===== design/sliding_window_similarity_match.sv =====
// Sliding window similarity matcher, top level.
// Uses swsm_pkg and swsm_score.
//
// Usage: characters enter on the in channel (i_in_valid / o_in_ready) with a
// sequence number and a start mark. The last PATTERN_MAX characters are kept
// in a shift register. For each character that completes a full window of the
// configured length, the newest characters are compared with the pattern and
// a hit (sequence number, start position, match count) is sent on the out
// channel (o_out_valid / i_out_ready) when count*100 >= percent*length.
// Configuration registers are written through i_cfg_valid / o_cfg_ready,
// which is always ready; write only while the block is idle.
// Throughput: one character per cycle while no hit is held back by a stall.
// A hit goes from the window shift register, loaded when its character is
// accepted, through compare, popcount and threshold test to the output register.
// Aligned pattern, mask and threshold are rebuilt from the configuration
// registers every cycle and registered; the compare uses the registered copies.
// Reset clears the window fill, position, sequence number and pipeline
// valids and restores the configuration defaults (length 1, percent 100).
// When the receiver stalls, the hit waits in the output register; characters
// that do not hit keep flowing, and the next hit is held at the scoring stage
// with o_in_ready low until the output register frees.
module sliding_window_similarity_match #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // character input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [swsm_pkg::CHAR_W-1:0]       i_base_char,
    input  logic                              i_sequence_start,
    input  logic [swsm_pkg::SEQ_W-1:0]        i_sequence_id,
    // hit output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [swsm_pkg::SEQ_W-1:0]        o_hit_sequence_id,
    output logic [swsm_pkg::POS_W-1:0]        o_hit_position,
    output logic [swsm_pkg::CNT_OUT_W-1:0]    o_match_count,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swsm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import swsm_pkg::*;

    localparam int LW  = $clog2(PATTERN_MAX + 1);
    localparam int PW  = PATTERN_MAX * CHAR_W;
    localparam int MW  = LW + PCT_W + 1;
    localparam logic [LW-1:0] LEN_MAX = LW'(PATTERN_MAX);

    // Configuration registers
    logic [PAT_REGS-1:0][CFG_DATA_W-1:0] r_pat;
    logic [LEN_REG_W-1:0]                r_len_cfg;
    logic [PCT_W-1:0]                    r_pct;

    // Derived configuration
    logic [LW-1:0]                             n_len, r_len;
    logic [MW-1:0]                             n_thresh, r_thresh;
    logic [PATTERN_MAX-1:0][CHAR_W-1:0]        pat_vec;
    logic [PW-1:0]                             n_apat;
    logic [PATTERN_MAX-1:0][CHAR_W-1:0]        r_apat;
    logic [PATTERN_MAX-1:0]                    n_mask, r_mask;
    logic [LW-1:0]                             shift_amt;

    // Stream state
    logic [PATTERN_MAX-1:0][CHAR_W-1:0] r_win, n_win;
    logic [LW-1:0]                      r_fill, n_fill;
    logic [POS_W-1:0]                   r_pos, n_pos;
    logic [SEQ_W-1:0]                   r_seq, n_seq;
    logic                               r_s1_valid;

    // Scoring stage
    logic [LW-1:0]    count;
    logic [MW-1:0]    scaled;
    logic             full, hit, out_free, s1_adv, in_acc;
    logic [POS_W-1:0] pos_out;

    // Output register
    logic                 r_out_valid;
    logic [SEQ_W-1:0]     r_out_seq;
    logic [POS_W-1:0]     r_out_pos;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat     <= '0;
            r_len_cfg <= LEN_RESET;
            r_pct     <= PCT_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PAT_0_7:   r_pat[0]  <= i_cfg_data;
                REG_PAT_8_15:  r_pat[1]  <= i_cfg_data;
                REG_PAT_16_23: r_pat[2]  <= i_cfg_data;
                REG_PAT_24_31: r_pat[3]  <= i_cfg_data;
                REG_LENGTH:    r_len_cfg <= i_cfg_data[LEN_REG_W-1:0];
                REG_PERCENT:   r_pct     <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length: zero acts as one, clamp at PATTERN_MAX
    always_comb begin
        if (r_len_cfg == '0) begin
            n_len = LW'(1);
        end else if ({1'b0, r_len_cfg} > (LEN_REG_W+1)'(PATTERN_MAX)) begin
            n_len = LEN_MAX;
        end else begin
            n_len = LW'(r_len_cfg);
        end
    end

    assign n_thresh = MW'(r_pct) * MW'(n_len);

    // Pattern characters; those beyond the register file read as zero
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
        if (k < PAT_CHARS) begin : g_reg
            assign pat_vec[k] = r_pat[k / 8][(k % 8) * CHAR_W +: CHAR_W];
        end else begin : g_zero
            assign pat_vec[k] = '0;
        end
    end

    // Align pattern char 0 with the oldest slot of the active window
    assign shift_amt = LEN_MAX - n_len;
    assign n_apat    = PW'(pat_vec) << (shift_amt * CHAR_W);
    assign n_mask    = {PATTERN_MAX{1'b1}} << shift_amt;

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_thresh <= n_thresh;
        r_apat   <= n_apat;
        r_mask   <= n_mask;
    end

    // Handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && (!hit || out_free);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // Next stream state for an accepted item
    always_comb begin
        for (int j = 0; j < PATTERN_MAX - 1; j++) begin
            n_win[j] = r_win[j+1];
        end
        n_win[PATTERN_MAX-1] = i_base_char;
        if (i_sequence_start) begin
            n_fill = LW'(1);
            n_pos  = POS_W'(1);
            n_seq  = i_sequence_id;
        end else begin
            n_fill = (r_fill < LEN_MAX) ? r_fill + LW'(1) : r_fill;
            n_pos  = (r_pos != '1) ? r_pos + POS_W'(1) : r_pos;
            n_seq  = r_seq;
        end
    end

    // Window shift register (no reset: the fill count guards reads)
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_pos      <= '0;
            r_seq      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_fill <= n_fill;
                r_pos  <= n_pos;
                r_seq  <= n_seq;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Compare and count
    swsm_score #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_score (
        .i_window  (r_win),
        .i_pattern (r_apat),
        .i_mask    (r_mask),
        .o_count   (count)
    );

    // Threshold test and window start position
    assign scaled  = MW'(count) * MW'(PCT_SCALE);
    assign full    = (r_fill >= r_len);
    assign hit     = full && (scaled >= r_thresh);
    assign pos_out = (r_pos == '1) ? r_pos : r_pos - POS_W'(r_len);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid && hit) begin
            r_out_seq <= r_seq;
            r_out_pos <= pos_out;
            r_out_cnt <= CNT_OUT_W'(count);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hit_sequence_id = r_out_seq;
    assign o_hit_position    = r_out_pos;
    assign o_match_count     = r_out_cnt;

endmodule

// ===== test/swsm_hit_checker.sv =====
// Hit checker for the sliding window similarity matcher.
// Watches the character, hit and register-write channels, predicts each hit and compares it.
// Depends on swsm_pkg.
module swsm_hit_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // character channel
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [swsm_pkg::CHAR_W-1:0]       i_base_char,
    input  logic                              i_sequence_start,
    input  logic [swsm_pkg::SEQ_W-1:0]        i_sequence_id,
    // hit channel
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [swsm_pkg::SEQ_W-1:0]        i_hit_sequence_id,
    input  logic [swsm_pkg::POS_W-1:0]        i_hit_position,
    input  logic [swsm_pkg::CNT_OUT_W-1:0]    i_match_count,
    // register writes
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [swsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swsm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // status for the top
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_chars_seen,
    output int                                o_hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import swsm_pkg::*;

    localparam int WIN        = PAT_CHARS;

    typedef struct packed {
        logic [SEQ_W-1:0]     seq;
        logic [POS_W-1:0]     pos;
        logic [CNT_OUT_W-1:0] count;
    } t_hit;

    // shadow configuration
    logic [CFG_DATA_W-1:0] pat_word [PAT_REGS];
    logic [LEN_REG_W-1:0]  len_reg;
    logic [PCT_W-1:0]      pct_reg;

    // shadow window state
    logic [CHAR_W-1:0]     window [WIN];
    int unsigned           fill;
    logic [POS_W-1:0]      position;
    logic [SEQ_W-1:0]      seq_latched;

    t_hit                  expected_hits [$];
    t_hit                  want;
    int                    fails;
    int                    chars;
    int                    hits;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] wanted);
        $display("hit check: %s: got %0h, expected %0h (t=%0t)", what, got, wanted,
                 $realtime);
        fails++;
    endtask

    // Shift one character into the window and queue the hit it should cause.
    task automatic score_char(input logic [CHAR_W-1:0] ch, input logic start,
                              input logic [SEQ_W-1:0] id);
        int   len;
        int   count;
        int   k;
        t_hit h;
        if (start) begin
            fill        = 0;
            position    = '0;
            seq_latched = id;
        end
        for (k = 0; k < WIN - 1; k++)
            window[k] = window[k + 1];
        window[WIN - 1] = ch;
        if (fill < WIN)
            fill++;
        if (position != '1)
            position++;

        // length zero acts as one, above the window as the full window
        len = (len_reg == 0) ? 1 : ((int'(len_reg) > WIN) ? WIN : int'(len_reg));
        if (fill < len)
            return;

        count = 0;
        for (k = 0; k < len; k++)
            if (window[WIN - len + k] == pat_word[k / 8][(k % 8) * 8 +: 8])
                count++;
        if (count * PCT_SCALE < int'(pct_reg) * len)
            return;

        h.seq   = seq_latched;
        h.pos   = (position == '1) ? '1 : position - POS_W'(len);
        h.count = CNT_OUT_W'(count);
        expected_hits.push_back(h);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (pat_word[r])
                pat_word[r] = '0;
            foreach (window[k])
                window[k] = '0;
            len_reg     = LEN_RESET;
            pct_reg     = PCT_RESET;
            fill        = 0;
            position    = '0;
            seq_latched = '0;
            expected_hits.delete();
        end else begin
            // compare the outgoing hit before taking in the new character
            if (i_out_valid && i_out_ready) begin
                hits++;
                if (expected_hits.size() == 0) begin
                    report_mismatch("hit with nothing expected, position",
                                    64'(i_hit_position), '0);
                end else begin
                    want = expected_hits.pop_front();
                    if (i_hit_sequence_id !== want.seq)
                        report_mismatch("sequence id", 64'(i_hit_sequence_id),
                                        64'(want.seq));
                    if (i_hit_position !== want.pos)
                        report_mismatch("position", 64'(i_hit_position), 64'(want.pos));
                    if (i_match_count !== want.count)
                        report_mismatch("match count", 64'(i_match_count), 64'(want.count));
                end
            end
            if (i_in_valid && i_in_ready) begin
                chars++;
                score_char(i_base_char, i_sequence_start, i_sequence_id);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_PAT_0_7:   pat_word[0] = i_cfg_data;
                    REG_PAT_8_15:  pat_word[1] = i_cfg_data;
                    REG_PAT_16_23: pat_word[2] = i_cfg_data;
                    REG_PAT_24_31: pat_word[3] = i_cfg_data;
                    REG_LENGTH:    len_reg     = i_cfg_data[LEN_REG_W-1:0];
                    REG_PERCENT:   pct_reg     = i_cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_hits.size();
        o_chars_seen <= chars;
        o_hits_seen  <= hits;
    end

endmodule

// ===== test/testbench.sv =====
// Top of the sliding window similarity matcher test: clock, reset, stimulus and verdict.
// Drives characters and register writes, stalls the hit channel; swsm_hit_checker does the checks.
// Depends on swsm_pkg, sliding_window_similarity_match and swsm_hit_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import swsm_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int ITEMS        = 1900;
    localparam int PHASES       = 25;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 8;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_in_valid       = 1'b0;
    logic [CHAR_W-1:0]      i_base_char      = '0;
    logic                   i_sequence_start = 1'b0;
    logic [SEQ_W-1:0]       i_sequence_id    = '0;
    logic                   i_out_ready      = 1'b0;
    logic                   i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data       = '0;

    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [SEQ_W-1:0]       o_hit_sequence_id;
    logic [POS_W-1:0]       o_hit_position;
    logic [CNT_OUT_W-1:0]   o_match_count;
    logic                   o_cfg_ready;

    int fail_count;
    int pending;
    int chars_seen;
    int hits_seen;

    int cycles        = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int stall_pct     = 0;
    int settings_used = 0;

    // stimulus shaping
    logic [CHAR_W-1:0] pat_bytes [PAT_CHARS];
    logic [CHAR_W-1:0] alphabet  [4];
    bit                full_range = 1'b1;
    int                eff_len    = 1;
    int                mutate_pct = 0;
    int                gap_max    = 0;
    int                plant_left = 0;
    int                plant_idx  = 0;

    always #2 i_clk = ~i_clk;

    sliding_window_similarity_match DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_base_char       (i_base_char),
        .i_sequence_start  (i_sequence_start),
        .i_sequence_id     (i_sequence_id),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_hit_sequence_id (o_hit_sequence_id),
        .o_hit_position    (o_hit_position),
        .o_match_count     (o_match_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    swsm_hit_checker hit_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_base_char       (i_base_char),
        .i_sequence_start  (i_sequence_start),
        .i_sequence_id     (i_sequence_id),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_hit_sequence_id (o_hit_sequence_id),
        .i_hit_position    (o_hit_position),
        .i_match_count     (o_match_count),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_chars_seen      (chars_seen),
        .o_hits_seen       (hits_seen)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d hits outstanding", cycles, pending);
            $display("testbench: errors");
            $finish;
        end
    end

    // Hit receiver: random ready runs, plus long hold-offs on request
    initial begin
        int run;
        forever begin
            @(posedge i_clk);
            if (holds_done < hold_requests) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
                run = $urandom_range(5);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic start,
                             input logic [SEQ_W-1:0] id);
        i_in_valid       <= 1'b1;
        i_base_char      <= ch;
        i_sequence_start <= start;
        i_sequence_id    <= id;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every outstanding hit, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    // Write all six registers while idle; upper bits of the narrow ones are junk
    task automatic apply_setting(input logic [LEN_REG_W-1:0] len, input logic [PCT_W-1:0] pct);
        logic [CFG_DATA_W-1:0] word;
        int r;
        int b;
        wait_idle();
        for (r = 0; r < PAT_REGS; r++) begin
            for (b = 0; b < 8; b++)
                word[b * 8 +: 8] = pat_bytes[r * 8 + b];
            write_reg(t_reg_idx'(int'(REG_PAT_0_7) + r), word);
        end
        word = {$urandom, $urandom};
        word[LEN_REG_W-1:0] = len;
        write_reg(REG_LENGTH, word);
        word = {$urandom, $urandom};
        word[PCT_W-1:0] = pct;
        write_reg(REG_PERCENT, word);
        i_cfg_valid <= 1'b0;
        eff_len = (len == 0) ? 1 : ((int'(len) > PAT_CHARS) ? PAT_CHARS : int'(len));
        settings_used++;
    endtask

    function automatic logic [CHAR_W-1:0] noise_char();
        return full_range ? CHAR_W'($urandom_range(255)) : alphabet[$urandom_range(3)];
    endfunction

    // Planted copies of the pattern with a few mutations, mixed with noise
    function automatic logic [CHAR_W-1:0] next_char();
        logic [CHAR_W-1:0] c;
        if (plant_left == 0 && $urandom_range(99) < 40) begin
            plant_left = eff_len;
            plant_idx  = 0;
        end
        if (plant_left > 0) begin
            c = pat_bytes[plant_idx];
            plant_idx++;
            plant_left--;
            if ($urandom_range(99) < mutate_pct)
                c = noise_char();
        end else begin
            c = noise_char();
        end
        return c;
    endfunction

    initial begin
        int                   phase;
        int                   sent;
        int                   burst;
        int                   per_phase;
        int                   b;
        logic [LEN_REG_W-1:0] len;
        logic [PCT_W-1:0]     pct;

        foreach (pat_bytes[k])
            pat_bytes[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, no start mark yet, so sequence 0 and the id is ignored
        send_char(8'h00, 1'b0, 8'hFF);
        send_char(8'hFF, 1'b0, 8'h00);

        // four-character pattern at 75 percent: exact match, no match, three of four
        pat_bytes[0] = 8'h00;
        pat_bytes[1] = 8'hFF;
        pat_bytes[2] = 8'hA5;
        pat_bytes[3] = 8'h5A;
        apply_setting(6'd4, 7'd75);
        send_char(8'h00, 1'b1, 8'hFF);
        send_char(8'hFF, 1'b0, 8'h11);
        send_char(8'hA5, 1'b0, 8'h22);
        send_char(8'h5A, 1'b0, 8'h33);
        send_char(8'h00, 1'b0, 8'h44);
        // start mark mid-stream restarts the window fill and position
        send_char(8'h00, 1'b1, 8'h00);
        send_char(8'hFF, 1'b0, 8'h55);
        send_char(8'hA5, 1'b0, 8'hAA);
        send_char(8'h00, 1'b0, 8'hFF);

        // length zero acts as one; percent zero makes every window hit
        apply_setting(6'd0, 7'd0);
        send_char(8'h7E, 1'b0, 8'hAB);
        send_char(8'h00, 1'b1, 8'h80);
        send_char(8'h81, 1'b0, 8'h7F);

        // length beyond the window, percent above 100: nothing can hit
        apply_setting(6'd63, 7'd127);
        send_char(8'h00, 1'b0, 8'h01);
        send_char(8'hFF, 1'b1, 8'hFE);
        send_char(8'h5A, 1'b0, 8'h02);

        // Random phases
        per_phase = ITEMS / PHASES;
        for (phase = 0; phase < PHASES; phase++) begin
            foreach (alphabet[k])
                alphabet[k] = CHAR_W'($urandom_range(255));
            full_range = ($urandom_range(5) == 0);
            for (b = 0; b < PAT_CHARS; b++)
                pat_bytes[b] = noise_char();

            case ($urandom_range(5))
                0:       len = LEN_REG_W'($urandom_range(1, 4));
                1:       len = LEN_REG_W'($urandom_range(1, 12));
                2:       len = LEN_REG_W'($urandom_range(1, 32));
                3:       len = LEN_REG_W'(PAT_CHARS);
                4:       len = '0;
                default: len = LEN_REG_W'($urandom_range(33, 63));
            endcase
            case ($urandom_range(5))
                0:       pct = '0;
                1:       pct = PCT_W'(PCT_SCALE);
                2:       pct = PCT_W'($urandom_range(100));
                3:       pct = PCT_W'($urandom_range(101, 127));
                default: pct = PCT_W'($urandom_range(60, 100));
            endcase
            mutate_pct = $urandom_range(30);
            case ($urandom_range(3))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 10;
            endcase
            case ($urandom_range(3))
                0:       stall_pct <= 0;
                1:       stall_pct <= 20;
                2:       stall_pct <= 50;
                default: stall_pct <= 75;
            endcase

            // back-pressure phases: every window hits, sender never idles, receiver holds off
            if (phase == 3 || phase == 14) begin
                len     = 6'd3;
                pct     = '0;
                gap_max = 0;
            end
            apply_setting(len, pct);
            if (phase == 3 || phase == 14 || phase == 20)
                hold_requests <= hold_requests + 1;

            plant_left = 0;
            sent = 0;
            while (sent < per_phase) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && sent < per_phase) begin
                    send_char(next_char(), ($urandom_range(99) < 3),
                              SEQ_W'($urandom_range(255)));
                    sent++;
                    burst--;
                end
                if (gap_max > 0)
                    pause_sender($urandom_range(gap_max));
            end
        end

        wait_idle();
        $display("run covered %0d characters and %0d checked hits over %0d register settings",
                 chars_seen, hits_seen, settings_used);
        $display("including %0d long receiver hold-offs against a full pipeline", holds_done);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
